// ===== rtl/tccw_pkg.sv =====
// Shared types and constants for the text console character writer.
package tccw_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;

    // Wide enough to address up to 16384 cells, e.g. a 256 x 64 screen.
    localparam int CMD_AW = 14;

    localparam logic       REQ_PUT    = 1'b0;
    localparam logic       REQ_READ   = 1'b1;
    localparam logic [7:0] CODE_BS    = 8'd8;
    localparam logic [7:0] CODE_TAB   = 8'd9;
    localparam logic [7:0] CODE_NL    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] ATTR_RESET = 8'h07;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  char_code;
        logic [10:0] cell_index;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [15:0] read_cell;
        logic        scrolled;
    } t_out_item;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic              is_read;
        logic              rd_ok;
        logic [CMD_AW-1:0] rd_addr;
        logic              w1_en;
        logic [CMD_AW-1:0] w1_addr;
        logic [7:0]        w1_char;
        logic              scroll;
        logic [CMD_AW-1:0] w2_addr;
        logic [4:0]        cur_row;
        logic [6:0]        cur_col;
    } t_cmd;

endpackage

// ===== rtl/tccw_fifo.sv =====
// Small synchronous queue of any packed type.
module tccw_fifo #(
    parameter type T     = logic [7:0],
    parameter int  DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T               r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!do_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== rtl/tccw_front.sv =====
// Front end: owns the cursor, classifies each request into a command.
module tccw_front
    import tccw_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    output t_cmd     o_cmd
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = $clog2(COLUMNS + TAB_WIDTH);
    localparam int PW    = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
    localparam logic [PW-1:0] LAST_PH = PW'((COLUMNS - 1) % TAB_WIDTH);

    logic [RW-1:0] r_row, n_row, w1_row;
    logic [CW-1:0] r_col, n_col, w1_col;
    logic [PW-1:0] r_phase, n_phase;     // column modulo tab width
    logic [SW-1:0] tab_sum;
    logic          w1_en, row_adv, scroll, is_read;
    logic [7:0]    w1_char;

    assign is_read = (i_item.req_type == REQ_READ);

    always_comb begin
        n_row   = r_row;
        n_col   = r_col;
        n_phase = r_phase;
        w1_en   = 1'b0;
        w1_row  = r_row;
        w1_col  = r_col;
        w1_char = i_item.char_code;
        row_adv = 1'b0;
        scroll  = 1'b0;
        tab_sum = SW'(r_col) + SW'(TAB_WIDTH) - SW'(r_phase);
        unique case (i_item.char_code)
            CODE_BS: begin
                if (r_row != '0 || r_col != '0) begin
                    w1_en   = 1'b1;
                    w1_char = CHAR_SPACE;
                    if (r_col == '0) begin
                        n_col   = CW'(COLUMNS - 1);
                        n_row   = r_row - 1'b1;
                        n_phase = LAST_PH;
                    end else begin
                        n_col   = r_col - 1'b1;
                        n_phase = (r_phase == '0) ? PW'(TAB_WIDTH - 1) : r_phase - 1'b1;
                    end
                    w1_row = n_row;
                    w1_col = n_col;
                end
            end
            CODE_NL: begin
                n_col   = '0;
                n_phase = '0;
                row_adv = 1'b1;
            end
            CODE_TAB: begin
                n_phase = '0;
                if (tab_sum >= SW'(COLUMNS)) begin
                    n_col   = '0;
                    row_adv = 1'b1;
                end else begin
                    n_col = CW'(tab_sum);
                end
            end
            default: begin
                w1_en = 1'b1;
                if (r_col == CW'(COLUMNS - 1)) begin
                    n_col   = '0;
                    n_phase = '0;
                    row_adv = 1'b1;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_phase = (r_phase == PW'(TAB_WIDTH - 1)) ? '0 : r_phase + 1'b1;
                end
            end
        endcase
        if (row_adv) begin
            if (r_row == RW'(ROWS - 1)) begin
                scroll = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_comb begin
        o_cmd.is_read = is_read;
        o_cmd.rd_ok   = (32'(i_item.cell_index) < CELLS);
        o_cmd.rd_addr = CMD_AW'(i_item.cell_index);
        o_cmd.w1_en   = w1_en;
        o_cmd.w1_addr = CMD_AW'(CMD_AW'(w1_row) * CMD_AW'(COLUMNS) + CMD_AW'(w1_col));
        o_cmd.w1_char = w1_char;
        o_cmd.scroll  = scroll;
        o_cmd.w2_addr = CMD_AW'(CMD_AW'(n_row) * CMD_AW'(COLUMNS) + CMD_AW'(n_col));
        o_cmd.cur_row = is_read ? 5'(r_row) : 5'(n_row);
        o_cmd.cur_col = is_read ? 7'(r_col) : 7'(n_col);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_phase <= '0;
        end else if (i_accept && !is_read) begin
            r_row   <= n_row;
            r_col   <= n_col;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== rtl/tccw_back.sv =====
// Back end: screen memory and the sequencer that carries out commands.
module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [7:0] i_attr,
    input  t_cmd      i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_pop,
    input  logic      i_out_full,
    output logic      o_out_push,
    output t_out_item o_out_item,
    output logic      o_init
);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_COPY = 3'd3;
    localparam logic [2:0] ST_ZERO = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;
    t_cmd          r_cmd;
    logic [15:0]   r_mem [CELLS];
    logic [15:0]   r_rdata;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [15:0]   wr_data;
    logic          wr_en, start;

    assign start     = (r_state == ST_IDLE) && !i_cmd_empty && !i_out_full;
    assign o_cmd_pop = start;
    assign o_init    = (r_state == ST_INIT);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        rd_addr    = i_cmd.rd_addr[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = r_cnt[AW-1:0];
        wr_data    = '0;
        o_out_push = 1'b0;
        o_out_item.cursor_row = r_cmd.cur_row;
        o_out_item.cursor_col = r_cmd.cur_col;
        o_out_item.read_cell  = '0;
        o_out_item.scrolled   = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                wr_en = 1'b1;
                if (r_cnt == NW'(CELLS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd.is_read) begin
                        n_state = ST_RD;
                    end else begin
                        wr_en   = i_cmd.w1_en;
                        wr_addr = i_cmd.w1_addr[AW-1:0];
                        wr_data = {i_attr, i_cmd.w1_char};
                        n_cnt   = '0;
                        n_state = i_cmd.scroll ? ST_COPY : ST_FIN;
                    end
                end
            end
            ST_RD: begin
                o_out_push           = 1'b1;
                o_out_item.read_cell = r_cmd.rd_ok ? r_rdata : '0;
                n_state              = ST_IDLE;
            end
            ST_COPY: begin
                // read one row ahead, write the word read last cycle
                rd_addr = AW'(r_cnt + NW'(COLUMNS));
                wr_en   = (r_cnt != '0);
                wr_addr = AW'(r_cnt - 1'b1);
                wr_data = r_rdata;
                if (r_cnt == NW'(CELLS - COLUMNS)) begin
                    n_state = ST_ZERO;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ZERO: begin
                wr_en = 1'b1;
                if (r_cnt == NW'(CELLS - 1)) begin
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIN: begin
                wr_en               = 1'b1;
                wr_addr             = r_cmd.w2_addr[AW-1:0];
                wr_data             = {i_attr, CHAR_SPACE};
                o_out_push          = 1'b1;
                o_out_item.scrolled = r_cmd.scroll;
                n_state             = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

endmodule

// ===== rtl/text_console_char_writer.sv =====
// A put or a read passes through the command queue, the back end and the output queue
// before its result shows. The back end takes a new command only when idle and the output queue has room.
// A scrolling put holds it while every row is copied up one row and the last row is zeroed.
// Reset: synchronous; cursor to origin, attribute to 7, queues emptied, then a clearing
// pass zeroes every screen cell with full held high.
module text_console_char_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  t_in_item   i_item,
    output logic       empty,
    input  logic       pop,
    output t_out_item  o_item,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data
);
    logic [7:0] r_attr;
    t_cmd       front_cmd, back_cmd;
    logic       cmd_full, cmd_empty, cmd_pop, accept;
    logic       out_full, out_push, init_busy;
    t_out_item  out_item;

    assign full   = cmd_full || init_busy;
    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_we) begin
            r_attr <= i_cfg_data;
        end
    end

    tccw_front #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_WIDTH(TAB_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_item  (i_item),
        .o_cmd   (front_cmd)
    );

    tccw_fifo #(
        .T    (t_cmd),
        .DEPTH(2)
    ) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_data (front_cmd),
        .o_full (cmd_full),
        .i_pop  (cmd_pop),
        .o_data (back_cmd),
        .o_empty(cmd_empty)
    );

    tccw_back #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_attr     (r_attr),
        .i_cmd      (back_cmd),
        .i_cmd_empty(cmd_empty),
        .o_cmd_pop  (cmd_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_item (out_item),
        .o_init     (init_busy)
    );

    tccw_fifo #(
        .T    (t_out_item),
        .DEPTH(2)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_data (out_item),
        .o_full (out_full),
        .i_pop  (pop),
        .o_data (o_item),
        .o_empty(empty)
    );

endmodule

// ===== rtl/tccw_checker.sv =====
// Port-level checks for the text console character writer, bound to the top level.
module tccw_assertions
    import tccw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
) (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input t_out_item o_item
);
    // screen clear runs right after reset, so input is refused
    a_full_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input not held off after reset");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_item.cursor_row) < ROWS))
        else $error("cursor row out of range");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_item.cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    a_scroll_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.scrolled) |->
            (32'(o_item.cursor_row) == ROWS - 1) && (o_item.read_cell == '0))
        else $error("scroll result inconsistent");

endmodule

bind text_console_char_writer tccw_assertions #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
) u_tccw_assertions (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .full   (full),
    .empty  (empty),
    .o_item (o_item)
);
